// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Sizes, codes and shared types of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // storage sizes
   localparam int CAPACITY     = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int LIST_MAX     = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int VAL_W        = 32;
   localparam int OCC_W        = 5;

   // opcodes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_LIST       = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [CNT_W-1:0]        count_type;

   // per-cell move controls, highest priority first
   typedef struct packed {
      logic load;        // take the request value
      logic take_left;   // shift toward the back
      logic take_right;  // shift toward the front
      logic take_head;   // wrap the front element in behind the last one
   } cell_ctrl_type;

endpackage

// ----- hdl/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque chain; picks its next word from the request
// or from a neighbor.
// ----------------------------------------------------------------------------
module bdq_cell (
   input  logic                  clock,
   input  bdq_pkg::cell_ctrl_type ctrl,
   input  bdq_pkg::value_type    req_value,
   input  bdq_pkg::value_type    left_value,
   input  bdq_pkg::value_type    right_value,
   input  bdq_pkg::value_type    head_value,
   output bdq_pkg::value_type    data_out
);
   import bdq_pkg::*;

   value_type data_ff;
   value_type data_in;

   // next word select
   always_comb begin
      if (ctrl.load) begin
         data_in = req_value;
      end else if (ctrl.take_left) begin
         data_in = left_value;
      end else if (ctrl.take_right) begin
         data_in = right_value;
      end else if (ctrl.take_head) begin
         data_in = head_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ----- hdl/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit words kept in a row of cells, front in
// cell zero. Pushes and pops shift the row, a listing rotates it once round.
// ----------------------------------------------------------------------------
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   request | req_valid req_stall req_opcode req_value      | in
//   result  | rsp_valid rsp_stall rsp_value_res            | out
//           | rsp_occupancy rsp_status rsp_last            |
//
// Push and pop results appear in the output register the cycle after the request
// is taken; unknown opcodes are taken but give no result.
// A listing steps the cell rotation once per element, one result a cycle
// unless the result stalls; no request is taken till the rotation is back in place.
// Reset clears the count and the control state; cell contents are kept.
// A stalled result holds the output register and with it all progress.
// ----------------------------------------------------------------------------
module bounded_deque (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_opcode,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_value_res,
   output logic [4:0]                   rsp_occupancy,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last
);
   import bdq_pkg::*;

   `include "assert_macros.svh"

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic          state_ff, state_in;
   count_type     count_ff, count_in;
   count_type     step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     value_ff, value_in;
   count_type     occ_ff, occ_in;
   logic [1:0]    status_ff, status_in;
   logic          last_ff, last_in;

   logic          out_free;
   logic          accept;
   logic          list_step;
   logic          is_full;
   logic          is_empty;
   value_type     back_value;

   cell_ctrl_type cell_ctrl [CAPACITY];
   value_type     cell_data [CAPACITY];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign list_step = (state_ff == S_LIST) && out_free;
   assign is_full   = (count_ff == count_type'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign back_value = cell_data[IDX_W'(count_ff - count_type'(1))];

   // cell row
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      value_type left_v;
      value_type right_v;
      if (k == 0) begin : g_first
         assign left_v = cell_data[k];
      end else begin : g_mid_l
         assign left_v = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_v = cell_data[k];
      end else begin : g_mid_r
         assign right_v = cell_data[k+1];
      end
      bdq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[k]),
         .req_value   (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_data[0]),
         .data_out    (cell_data[k])
      );
   end

   // per-cell move controls
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         cell_ctrl[k].load = accept && !is_full &&
            (((req_opcode == OP_PUSH_FRONT) && (k == 0)) ||
             ((req_opcode == OP_PUSH_BACK) && (count_ff == count_type'(k))));
         cell_ctrl[k].take_left = accept && !is_full &&
            (req_opcode == OP_PUSH_FRONT) && (k != 0);
         cell_ctrl[k].take_right =
            (accept && !is_empty && (req_opcode == OP_POP_FRONT) && (k != CAPACITY - 1)) ||
            (list_step && (count_type'(k + 1) < count_ff));
         cell_ctrl[k].take_head = list_step && (count_type'(k + 1) == count_ff);
      end
   end

   // request decode, listing sequencer and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      value_in     = value_ff;
      occ_in       = occ_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      if (accept) begin
         unique case (req_opcode) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               value_in     = '0;
               last_in      = 1'b1;
               if (is_full) begin
                  status_in = ST_FULL;
                  occ_in    = count_ff;
               end else begin
                  status_in = ST_OK;
                  count_in  = count_ff + count_type'(1);
                  occ_in    = count_ff + count_type'(1);
               end
            end
            OP_LIST: begin
               if (is_empty) begin
                  rsp_valid_in = 1'b1;
                  value_in     = '0;
                  occ_in       = '0;
                  status_in    = ST_EMPTY;
                  last_in      = 1'b1;
               end else begin
                  state_in = S_LIST;
                  step_in  = '0;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               if (is_empty) begin
                  value_in  = '0;
                  occ_in    = '0;
                  status_in = ST_EMPTY;
               end else begin
                  value_in  = (req_opcode == OP_POP_FRONT) ? cell_data[0] : back_value;
                  status_in = ST_OK;
                  count_in  = count_ff - count_type'(1);
                  occ_in    = count_ff - count_type'(1);
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end else if (list_step) begin
         // emit the current front while the row rotates by one
         rsp_valid_in = (step_ff < count_type'(LIST_MAX));
         value_in     = cell_data[0];
         occ_in       = count_ff;
         status_in    = ST_OK;
         last_in      = ((step_ff + count_type'(1)) == count_ff) ||
                        ((step_ff + count_type'(1)) == count_type'(LIST_MAX));
         step_in      = step_ff + count_type'(1);
         if ((step_ff + count_type'(1)) == count_ff) begin
            state_in = S_IDLE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      occ_ff    <= occ_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = value_ff;
   assign rsp_occupancy = OCC_W'(occ_ff);
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, count_ff <= count_type'(CAPACITY), "count above capacity")
   `ASSERT_IMPLY(a_list_blocks, state_ff == S_LIST, req_stall, "request taken during listing")
   `ASSERT_NEXT(a_full_drop, accept && is_full && (req_opcode == OP_PUSH_BACK),
      rsp_valid && (rsp_status == ST_FULL) && $stable(count_ff), "full push not dropped")
   `ASSERT_IMPLY(a_list_ok, state_ff == S_LIST, !is_empty, "listing an empty row")

endmodule

// ----- bench/deque_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// deque_scoreboard_pkg
// Shadow copy of the bounded deque used by the bench: it tracks the stored
// elements, derives the answers each request causes and compares them with
// the answers the block returns, oldest first.
// ----------------------------------------------------------------------------
package deque_scoreboard_pkg;

   import bdq_pkg::*;

   // opcodes past the last defined one, ignored by the block
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // one answer as seen on the result channel
   typedef struct {
      value_type  value_res;
      logic [4:0] occupancy;
      logic [1:0] status;
      logic       last;
   } deque_answer_type;

   class deque_scoreboard;

      value_type        cells [CAPACITY];
      int               head;
      int               count;
      deque_answer_type answers_due [$];
      int               failures;

      function new();
         head     = 0;
         count    = 0;
         failures = 0;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      // queue one expected answer, occupancy taken from the current count
      function void add_answer(value_type v, logic [1:0] st, logic lst);
         deque_answer_type a;
         a.value_res = v;
         a.occupancy = 5'(count);
         a.status    = st;
         a.last      = lst;
         answers_due.push_back(a);
      endfunction

      // apply one accepted request to the shadow deque
      function void note_request(logic [2:0] op, value_type v);
         int n;
         int slot;
         case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (count >= CAPACITY) begin
                  add_answer('0, ST_FULL, 1'b1);
               end else begin
                  if (op == OP_PUSH_FRONT) begin
                     head = (head + CAPACITY - 1) % CAPACITY;
                     slot = head;
                  end else begin
                     slot = (head + count) % CAPACITY;
                  end
                  cells[slot] = v;
                  count++;
                  add_answer('0, ST_OK, 1'b1);
               end
            end
            OP_LIST: begin
               if (count == 0) begin
                  add_answer('0, ST_EMPTY, 1'b1);
               end else begin
                  n = (count < RESULT_LIMIT) ? count : RESULT_LIMIT;
                  for (int i = 0; i < n; i++)
                     add_answer(cells[(head + i) % CAPACITY], ST_OK, i == n - 1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (count == 0) begin
                  add_answer('0, ST_EMPTY, 1'b1);
               end else begin
                  if (op == OP_POP_FRONT) begin
                     slot = head;
                     head = (head + 1) % CAPACITY;
                  end else begin
                     slot = (head + count - 1) % CAPACITY;
                  end
                  count--;
                  add_answer(cells[slot], ST_OK, 1'b1);
               end
            end
            // spare opcodes leave the state alone and answer nothing
            default: ;
         endcase
      endfunction

      // compare one returned answer with the oldest one due
      function void check_result(value_type v, logic [4:0] occ, logic [1:0] st,
                                 logic lst);
         deque_answer_type a;
         if (answers_due.size() == 0) begin
            $error("unexpected result: value_res %0d occupancy %0d status %0d last %0b",
                   v, occ, st, lst);
            failures++;
            return;
         end
         a = answers_due.pop_front();
         if (v !== a.value_res) begin
            $error("value_res mismatch: expected %0d, actual %0d", a.value_res, v);
            failures++;
         end
         if (occ !== a.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", a.occupancy, occ);
            failures++;
         end
         if (st !== a.status) begin
            $error("status mismatch: expected %0d, actual %0d", a.status, st);
            failures++;
         end
         if (lst !== a.last) begin
            $error("last mismatch: expected %0b, actual %0b", a.last, lst);
            failures++;
         end
      endfunction

   endclass

endpackage

// ----- bench/tb_bounded_deque.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_deque
// Drives pushes, pops and listings into the bounded deque with random gaps
// and result stalls, and checks every answer against a shadow deque.
// ----------------------------------------------------------------------------
module tb_bounded_deque;

   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;
   import deque_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS   = 350;
   localparam int CALM_ITEMS     = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 24;

   typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} workload_type;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_stall;
   logic [2:0]       req_opcode    = OP_PUSH_FRONT;
   logic signed [31:0] req_value   = '0;
   logic             rsp_valid;
   logic             rsp_stall     = 1'b0;
   logic signed [31:0] rsp_value_res;
   logic [4:0]       rsp_occupancy;
   logic [1:0]       rsp_status;
   logic             rsp_last;

   deque_scoreboard  sb = new();
   bit               calm_tail = 1'b0;
   int               quiet_cycles = 0;

   bounded_deque u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_occupancy (rsp_occupancy),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   // check answers, record taken requests, and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_value_res, rsp_occupancy, rsp_status, rsp_last);
         if (req_valid && !req_stall)
            sb.note_request(req_opcode, req_value);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result stalls in random bursts, with calm stretches between
   initial begin : rsp_backpressure
      int  run;
      int  mode_left;
      bit  busy;
      run       = 0;
      mode_left = 0;
      busy      = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            busy      = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (run == 0 && busy && !calm_tail && $urandom_range(0, 5) == 0)
            run = $urandom_range(1, 12);
         // no stalls at all once the calm tail starts
         if (calm_tail)
            run = 0;
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // present one request and hold it until taken
   task automatic send_request(input logic [2:0] op, input logic signed [31:0] v);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid for an idle gap set by n, payload scrambled meanwhile
   task automatic idle_sender(input int n);
      @(negedge clock);
      req_valid  <= 1'b0;
      req_opcode <= 3'($urandom);
      req_value  <= $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   // hold off until every outstanding answer is back
   task automatic drain_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return ($urandom_range(0, 1) != 0) ? 32'sh0 : -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_opcode(input workload_type lean);
      int r;
      int push_pct;
      r = $urandom_range(0, 99);
      case (lean)
         LEAN_FILL:  push_pct = 80;
         LEAN_DRAIN: push_pct = 12;
         default:    push_pct = 42;
      endcase
      if (r < 3)
         return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (r < 3 + push_pct)
         return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (r < 3 + push_pct + 8)
         return OP_LIST;
      return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   initial begin : stimulus
      int           useful;
      int           phase_left;
      workload_type lean;
      bit           sender_busy;
      logic [2:0]   op;
      useful      = 0;
      phase_left  = 0;
      lean        = LEAN_EVEN;
      sender_busy = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store on every read-type request
      send_request(OP_LIST, 32'sd5);
      send_request(OP_POP_FRONT, -32'sd1);
      send_request(OP_POP_BACK, 32'sh7fff_ffff);
      // extremes pushed at both ends
      send_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(OP_PUSH_BACK, 32'sh8000_0000);
      send_request(OP_PUSH_FRONT, 32'sh0);
      send_request(OP_PUSH_BACK, -32'sd1);
      send_request(OP_LIST, 32'sh0);
      // spare opcodes are ignored
      send_request(OP_SPARE_LO, 32'sh1234_5678);
      send_request(3'(OP_SPARE_LO + 1), -32'sd1);
      send_request(OP_SPARE_HI, 32'sh8000_0000);
      send_request(OP_POP_FRONT, 32'sh0);
      send_request(OP_POP_BACK, 32'sh0);
      send_request(OP_LIST, 32'sh0);
      send_request(OP_POP_FRONT, 32'sh0);
      send_request(OP_POP_BACK, 32'sh0);
      send_request(OP_POP_BACK, 32'sh0);
      send_request(OP_LIST, 32'sh0);
      drain_answers();

      // random phases leaning toward full, toward empty, or balanced
      while (useful < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            lean        = workload_type'($urandom_range(0, 2));
            phase_left  = $urandom_range(20, 45);
            sender_busy = ($urandom_range(0, 2) != 0);
         end
         calm_tail = (useful >= RANDOM_ITEMS - CALM_ITEMS);
         if (!calm_tail && sender_busy && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 12));
         op = pick_opcode(lean);
         send_request(op, pick_value());
         if (op <= OP_POP_BACK) begin
            useful++;
            phase_left--;
            if (useful == RANDOM_ITEMS / 2)
               drain_answers();
         end
      end

      drain_answers();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bounded_deque.sv
bench/deque_scoreboard_pkg.sv
bench/tb_bounded_deque.sv
